// File: design/interrupt_line_bitmap_allocator_unit_macros.svh
// assertion macros for the interrupt line allocator checker
`ifndef INTERRUPT_LINE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define INTERRUPT_LINE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ILBA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define ILBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// File: design/ilba_pkg.sv
// shared types and constants of the interrupt line allocator
package ilba_pkg;

	localparam int LINE_W   = 10;
	localparam int BASE_W   = 10;
	localparam int INPUTS_W = 7;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;
	localparam int SUM_W    = 11;
	localparam int CNT_W    = 9;
	localparam int CFG_CHIPS = 4;
	localparam int LINE_SPAN = 1024;
	localparam int TDATA_W  = 16;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	// low bit of a register index selects base or input count
	localparam logic REG_KIND_BASE   = 1'b0;
	localparam logic REG_KIND_INPUTS = 1'b1;

	localparam logic FUNC_RESERVE = 1'b0;
	localparam logic FUNC_FREE    = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FREED   = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef struct packed {
		logic [BASE_W-1:0]   base;
		logic [INPUTS_W-1:0] inputs;
	} chip_cfg_t;

	typedef chip_cfg_t [CFG_CHIPS-1:0] chip_cfg_arr_t;

endpackage

// File: design/ilba_cfg_regs.sv
// apb register file holding base and input count of each controller
module ilba_cfg_regs
	import ilba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output chip_cfg_arr_t     cfg
);

	chip_cfg_arr_t cfg_q;
	logic          wr_en;
	logic [1:0]    chip_sel;
	logic          kind_sel;

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite;
	assign chip_sel = paddr[4:3];
	assign kind_sel = paddr[2];
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (kind_sel)
				REG_KIND_BASE:   cfg_q[chip_sel].base   <= pwdata[BASE_W-1:0];
				REG_KIND_INPUTS: cfg_q[chip_sel].inputs <= pwdata[INPUTS_W-1:0];
				default:         cfg_q[chip_sel].base   <= cfg_q[chip_sel].base;
			endcase
		end
	end

	always_comb begin
		case (kind_sel)
			REG_KIND_BASE:   prdata = APB_DW'(cfg_q[chip_sel].base);
			REG_KIND_INPUTS: prdata = APB_DW'(cfg_q[chip_sel].inputs);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: design/ilba_usage_mem.sv
// usage bitmap memory, one word per read, with per-word valid bits for reset
module ilba_usage_mem
	import ilba_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic              wr_en,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[addr];
			end
		end
	end

	// a word never written reads as all free
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// File: design/interrupt_line_bitmap_allocator_unit.sv
// top level of the interrupt line allocator: request sequencer and result register
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: line; tuser: func, any_line
// m_*       out  m_tvalid/m_tready  tdata: granted_line; tuser: status
// apb       in   psel/penable       controller base and input count registers
//
// free or specific reserve: accept, look up the controllers in order,
// then read and check the bitmap word when a controller holds the line, then finish.
// reserve any: accept, then for each scanned controller a lookup and a read and
// check per bitmap word, then finish; read and check share the single memory port.
// reset clears the valid bit of every bitmap word at once, no clearing pass.
// a waiting result does not block the next request; only finishing waits for m_tready.
module interrupt_line_bitmap_allocator_unit
	import ilba_pkg::*;
#(
	parameter int MAX_INPUTS = 128,
	parameter int CHIPS      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [9:0] line
	input  logic [1:0]         s_tuser,   // [0] func, [1] any_line
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [9:0] granted_line
	output logic [1:0]         m_tuser,   // [1:0] status
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int WPC   = (MAX_INPUTS + WORD_W - 1) / WORD_W;
	localparam int DEPTH = CHIPS * WPC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW    = (WPC > 1) ? $clog2(WPC) : 1;
	localparam int CW    = (CHIPS > 1) ? $clog2(CHIPS) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FIND  = 5'b00010,
		S_READ  = 5'b00100,
		S_CHECK = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	chip_cfg_arr_t cfg;

	logic              func_q;
	logic              any_q;
	logic [LINE_W-1:0] line_q;
	logic [CW-1:0]     chip_q;
	logic [WW-1:0]     w_q;
	logic [BIT_W-1:0]  bit_q;
	logic [LINE_W-1:0] res_line_q;
	status_t           res_status_q;

	logic               m_tvalid_q;
	logic [LINE_W-1:0]  m_line_q;
	status_t            m_status_q;

	// per-controller range of the controller under test
	chip_cfg_t         cur_cfg;
	logic [CNT_W-1:0]  n_c;
	logic [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]  eff_c;
	logic              in_range;
	logic [LINE_W-1:0] k_c;
	logic              last_chip;

	// memory port
	logic              mem_rd;
	logic              mem_wr;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	// first free bit search on the fetched word
	logic [SUM_W-1:0]  kbase;
	logic [WORD_W-1:0] avail;
	logic              found;
	logic [BIT_W-1:0]  first_b;
	logic              more_words;

	logic              accept;
	logic              out_free;

	ilba_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ilba_usage_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (mem_rd),
		.wr_en  (mem_wr),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	assign accept   = s_tvalid & s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cur_cfg   = cfg[2'(chip_q)];
		n_c       = (CNT_W'(cur_cfg.inputs) > CNT_W'(MAX_INPUTS)) ?
			CNT_W'(MAX_INPUTS) : CNT_W'(cur_cfg.inputs);
		sum_c     = SUM_W'(cur_cfg.base) + SUM_W'(n_c);
		// clip a range that runs past the last line
		eff_c     = (sum_c > SUM_W'(LINE_SPAN)) ?
			SUM_W'(LINE_SPAN) - SUM_W'(cur_cfg.base) : SUM_W'(n_c);
		in_range  = (line_q >= cur_cfg.base) && (SUM_W'(line_q) < sum_c);
		k_c       = line_q - cur_cfg.base;
		last_chip = (chip_q == CW'(CHIPS - 1));
	end

	assign mem_addr = AW'(chip_q * WPC) + AW'(w_q);

	always_comb begin
		kbase = SUM_W'({w_q, {BIT_W{1'b0}}});
		for (int b = 0; b < WORD_W; b++) begin
			avail[b] = !mem_rdata[b] && ((kbase + SUM_W'(b)) < eff_c);
		end
		found   = |avail;
		first_b = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (avail[b]) begin
				first_b = BIT_W'(b);
			end
		end
		more_words = (w_q != WW'(WPC - 1)) && ((kbase + SUM_W'(WORD_W)) < eff_c);
	end

	always_comb begin
		mem_rd    = (state_q == S_READ);
		mem_wr    = 1'b0;
		mem_wdata = mem_rdata;
		if (state_q == S_CHECK) begin
			if (func_q == FUNC_FREE) begin
				mem_wr    = 1'b1;
				mem_wdata = mem_rdata & ~(WORD_W'(1) << bit_q);
			end else if (any_q) begin
				mem_wr    = found;
				mem_wdata = mem_rdata | (WORD_W'(1) << first_b);
			end else begin
				mem_wr    = !mem_rdata[bit_q];
				mem_wdata = mem_rdata | (WORD_W'(1) << bit_q);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_FIND;
			S_FIND: begin
				if (any_q && func_q == FUNC_RESERVE) begin
					if (eff_c != '0)    state_d = S_READ;
					else if (last_chip) state_d = S_DONE;
				end else begin
					if (in_range)       state_d = S_READ;
					else if (last_chip) state_d = S_DONE;
				end
			end
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (func_q == FUNC_FREE || !any_q || found) state_d = S_DONE;
				else if (more_words)                       state_d = S_READ;
				else if (last_chip)                        state_d = S_DONE;
				else                                       state_d = S_FIND;
			end
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q       <= s_tuser[0];
					any_q        <= s_tuser[1];
					line_q       <= s_tdata[LINE_W-1:0];
					chip_q       <= '0;
					w_q          <= '0;
					bit_q        <= '0;
					res_line_q   <= '0;
					res_status_q <= (s_tuser[0] == FUNC_FREE) ? ST_OUTSIDE : ST_REFUSED;
				end
			end
			S_FIND: begin
				if (any_q && func_q == FUNC_RESERVE) begin
					w_q <= '0;
					if (eff_c == '0 && !last_chip) chip_q <= chip_q + CW'(1);
				end else if (in_range) begin
					w_q   <= k_c[BIT_W +: WW];
					bit_q <= k_c[BIT_W-1:0];
				end else if (!last_chip) begin
					chip_q <= chip_q + CW'(1);
				end
			end
			S_CHECK: begin
				if (func_q == FUNC_FREE) begin
					res_status_q <= ST_FREED;
				end else if (!any_q) begin
					if (!mem_rdata[bit_q]) begin
						res_status_q <= ST_GRANTED;
						res_line_q   <= line_q;
					end
				end else if (found) begin
					res_status_q <= ST_GRANTED;
					res_line_q   <= cur_cfg.base + LINE_W'(kbase) + LINE_W'(first_b);
				end else if (more_words) begin
					w_q <= w_q + WW'(1);
				end else if (!last_chip) begin
					chip_q <= chip_q + CW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_line_q   <= res_line_q;
					m_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_line_q);
	assign m_tuser  = m_status_q;

endmodule

// File: design/ilba_checker.sv
// port-level checker for the interrupt line allocator, bound to the top level
`include "interrupt_line_bitmap_allocator_unit_macros.svh"

module ilba_checker
	import ilba_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [1:0]         m_tuser
);

	// a refused or free result never carries a line
	`ILBA_ASSERT_SAME(a_no_line_unless_granted, m_tvalid && m_tuser != ST_GRANTED, m_tdata == '0)

	// the sequencer works one request at a time
	`ILBA_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)

	// a request ends with a result, so a new one waits at least past the lookup
	`ILBA_ASSERT_NEXT(a_result_not_instant, s_tvalid && s_tready, !(s_tvalid && s_tready))

	// stalled result holds
	`ILBA_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind interrupt_line_bitmap_allocator_unit ilba_checker u_ilba_checker (.*);

// File: tb/sv/interrupt_line_bitmap_allocator_unit_checker.sv
// checker that mirrors the allocator bitmaps and compares every result with its prediction
module interrupt_line_bitmap_allocator_unit_checker
	import ilba_pkg::*;
#(
	parameter int MAX_INPUTS = 128,
	parameter int CHIPS      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [9:0] line
	input  logic [1:0]         s_tuser,   // [0] func, [1] any_line
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [9:0] granted_line
	input  logic [1:0]         m_tuser,   // [1:0] status
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output int                 mismatches,
	output int                 pending,
	output int                 outcomes_checked,
	output int                 grants_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [LINE_W-1:0] line;
		status_t           status;
	} outcome_t;

	logic [BASE_W-1:0]     chip_base   [CFG_CHIPS];
	logic [INPUTS_W-1:0]   chip_inputs [CFG_CHIPS];
	logic [MAX_INPUTS-1:0] line_used   [CFG_CHIPS];
	outcome_t              awaited_outcomes [$];

	// inputs of a controller that map onto real lines
	function automatic int usable_lines(int c);
		int n;
		n = int'(chip_inputs[c]);
		if (n > MAX_INPUTS)
			n = MAX_INPUTS;
		if (int'(chip_base[c]) + n > LINE_SPAN)
			n = LINE_SPAN - int'(chip_base[c]);
		return n;
	endfunction

	// lowest-numbered controller whose range holds the line
	function automatic int owning_chip(int line);
		for (int c = 0; c < CHIPS; c++)
			if (line >= int'(chip_base[c]) && line < int'(chip_base[c]) + usable_lines(c))
				return c;
		return -1;
	endfunction

	function automatic outcome_t allocate_or_free(logic func, logic any,
			logic [LINE_W-1:0] line);
		outcome_t res;
		int c;
		int k;
		res.line   = '0;
		res.status = ST_REFUSED;
		if (func == FUNC_FREE) begin
			c = owning_chip(int'(line));
			if (c >= 0) begin
				line_used[c][int'(line) - int'(chip_base[c])] = 1'b0;
				res.status = ST_FREED;
			end else begin
				res.status = ST_OUTSIDE;
			end
		end else if (any) begin
			for (c = 0; c < CHIPS && res.status != ST_GRANTED; c++)
				for (k = 0; k < usable_lines(c); k++)
					if (!line_used[c][k]) begin
						line_used[c][k] = 1'b1;
						res.line   = LINE_W'(int'(chip_base[c]) + k);
						res.status = ST_GRANTED;
						break;
					end
		end else begin
			c = owning_chip(int'(line));
			if (c >= 0) begin
				k = int'(line) - int'(chip_base[c]);
				if (!line_used[c][k]) begin
					line_used[c][k] = 1'b1;
					res.line   = line;
					res.status = ST_GRANTED;
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int       errs;
		int       grants;
		logic [2:0] index;
		errs   = 0;
		grants = 0;
		if (!arst_n) begin
			for (int c = 0; c < CFG_CHIPS; c++) begin
				chip_base[c]   = '0;
				chip_inputs[c] = '0;
				line_used[c]   = '0;
			end
			awaited_outcomes.delete();
			mismatches       <= 0;
			pending          <= 0;
			outcomes_checked <= 0;
			grants_seen      <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				index = paddr[APB_AW-1:2];
				if (index[0] == REG_KIND_BASE)
					chip_base[index[2:1]] = pwdata[BASE_W-1:0];
				else
					chip_inputs[index[2:1]] = pwdata[INPUTS_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (awaited_outcomes.size() == 0) begin
					$display("%t unexpected result: expected none, got line %0d status %0d",
						$time, m_tdata[LINE_W-1:0], m_tuser);
					errs++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (m_tdata[LINE_W-1:0] !== want.line) begin
						$display("%t granted_line mismatch: expected %0d, got %0d",
							$time, want.line, m_tdata[LINE_W-1:0]);
						errs++;
					end
					if (m_tuser !== 2'(want.status)) begin
						$display("%t status mismatch: expected %0d (%s), got %0d",
							$time, want.status, want.status.name(), m_tuser);
						errs++;
					end
					if (want.status == ST_GRANTED)
						grants = 1;
					outcomes_checked <= outcomes_checked + 1;
				end
			end
			if (s_tvalid && s_tready)
				awaited_outcomes.push_back(allocate_or_free(s_tuser[0], s_tuser[1],
					s_tdata[LINE_W-1:0]));
			mismatches  <= mismatches + errs;
			grants_seen <= grants_seen + grants;
			pending     <= awaited_outcomes.size();
		end
	end

endmodule

// File: tb/sv/interrupt_line_bitmap_allocator_unit_test.sv
// regression top for the interrupt line allocator: clock, reset, requests and verdict
module interrupt_line_bitmap_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ilba_pkg::*;

	localparam int STALL_PCT       = 25;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 64;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;   // [9:0] line
	logic [1:0]         s_tuser  = '0;   // [0] func, [1] any_line
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;         // [9:0] granted_line
	logic [1:0]         m_tuser;         // [1:0] status
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [APB_AW-1:0]  paddr    = '0;
	logic [APB_DW-1:0]  pwdata   = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	logic calm = 1'b0;
	int   mismatches;
	int   pending;
	int   outcomes_checked;
	int   grants_seen;
	int   requests_sent = 0;
	int   layouts = 0;
	int   idle_cycles = 0;

	logic [BASE_W-1:0]   layout_base   [CFG_CHIPS];
	logic [INPUTS_W-1:0] layout_inputs [CFG_CHIPS];

	interrupt_line_bitmap_allocator_unit dut (.*);

	interrupt_line_bitmap_allocator_unit_checker watcher (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatches, .pending, .outcomes_checked, .grants_seen
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic func, input logic any,
			input logic [LINE_W-1:0] line);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(line);
		s_tuser  <= {any, func};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	// hold the request side until every pending result is back
	task automatic wait_for_outcomes();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({index, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
	endtask

	task automatic program_layout();
		for (int c = 0; c < CFG_CHIPS; c++) begin
			write_reg({c[1:0], REG_KIND_BASE}, APB_DW'(layout_base[c]));
			write_reg({c[1:0], REG_KIND_INPUTS}, APB_DW'(layout_inputs[c]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		layouts++;
	endtask

	task automatic set_chip(input int c, input int base, input int inputs);
		layout_base[c]   = BASE_W'(base);
		layout_inputs[c] = INPUTS_W'(inputs);
	endtask

	// mostly small pools so they fill up, some near the top line, some overlapping
	function automatic void shuffle_layout();
		for (int c = 0; c < CFG_CHIPS; c++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 15)
				layout_inputs[c] = '0;
			else if (pick < 75)
				layout_inputs[c] = INPUTS_W'($urandom_range(1, 12));
			else
				layout_inputs[c] = INPUTS_W'($urandom_range(13, 127));
			pick = $urandom_range(0, 99);
			if (pick < 20)
				layout_base[c] = BASE_W'($urandom_range(1000, LINE_SPAN - 1));
			else if (pick < 45 && c > 0)
				layout_base[c] = layout_base[c - 1] + BASE_W'($urandom_range(0, 8));
			else
				layout_base[c] = BASE_W'($urandom_range(0, LINE_SPAN - 1));
		end
	endfunction

	function automatic logic [LINE_W-1:0] pick_line();
		int c;
		c = $urandom_range(0, CFG_CHIPS - 1);
		if (layout_inputs[c] != 0 && $urandom_range(0, 99) < 75)
			return layout_base[c] + LINE_W'($urandom_range(0, int'(layout_inputs[c]) - 1));
		return LINE_W'($urandom_range(0, LINE_SPAN - 1));
	endfunction

	initial begin
		int op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every controller absent after reset
		send_request(FUNC_RESERVE, 1'b1, 10'd0);
		send_request(FUNC_RESERVE, 1'b0, 10'd0);
		send_request(FUNC_FREE, 1'b0, 10'd1023);
		wait_for_outcomes();

		// clipped top range, an overlapping second pool, one absent, one tiny
		set_chip(0, 1020, 127);
		set_chip(1, 1022, 2);
		set_chip(2, 0, 0);
		set_chip(3, 5, 2);
		program_layout();
		send_request(FUNC_RESERVE, 1'b0, 10'd1023);
		send_request(FUNC_RESERVE, 1'b0, 10'd1023);
		repeat (7)
			send_request(FUNC_RESERVE, 1'b1, 10'd0);
		send_request(FUNC_RESERVE, 1'b1, 10'd1023);
		send_request(FUNC_FREE, 1'b0, 10'd1022);
		send_request(FUNC_FREE, 1'b0, 10'd1022);
		send_request(FUNC_FREE, 1'b0, 10'd0);
		send_request(FUNC_FREE, 1'b0, 10'd7);
		send_request(FUNC_RESERVE, 1'b0, 10'd1022);
		send_request(FUNC_RESERVE, 1'b0, 10'd4);
		send_request(FUNC_RESERVE, 1'b1, 10'd1023);
		send_request(FUNC_FREE, 1'b1, 10'd5);
		send_request(FUNC_RESERVE, 1'b0, 10'd5);

		for (int p = 0; p < PHASES; p++) begin
			wait_for_outcomes();
			if (p == 0) begin
				for (int c = 0; c < CFG_CHIPS; c++)
					set_chip(c, 1023, 127);
			end else if (p == 1) begin
				set_chip(0, 0, 127);
				set_chip(1, 127, 127);
				set_chip(2, 254, 127);
				set_chip(3, 960, 127);
			end else begin
				shuffle_layout();
			end
			program_layout();
			calm <= (p == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) == 0)
					wait_for_outcomes();
				op = $urandom_range(0, 99);
				if (op < 35)
					send_request(FUNC_RESERVE, 1'b1, LINE_W'($urandom_range(0, LINE_SPAN - 1)));
				else if (op < 65)
					send_request(FUNC_RESERVE, 1'b0, pick_line());
				else
					send_request(FUNC_FREE, 1'($urandom_range(0, 1)), pick_line());
			end
		end

		wait_for_outcomes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests over %0d controller layouts: overlaps, clipped ranges, full pools",
			requests_sent, layouts);
		$display("%0d results compared, %0d of them grants", outcomes_checked, grants_seen);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
